/* src/fflc_pkg.sv */
package fflc_pkg;

   // wait timer width
   localparam int TIMER_W = 16;

   // telemetry beats per report
   localparam int N_BEATS = 5;
   localparam int BEAT_W  = $clog2(N_BEATS);
   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(N_BEATS - 1);

   // floor(n/100) = (n * 5243) >> 19 holds for n below 43690; the x83 and x39
   // scalings are folded into one constant multiplier each
   localparam int DIV_SHIFT = 19;
   localparam logic [18:0] MUL_POS = 19'd435169;   // 83 * 5243
   localparam logic [17:0] MUL_CUR = 18'd204477;   // 39 * 5243

   // reset values of the control registers
   localparam logic [15:0] DWELL_RESET = 16'd2000;
   localparam logic [15:0] PAUSE_RESET = 16'd500;
   localparam logic [7:0]  TOP_RESET   = 8'd215;
   localparam logic [9:0]  DUTY_RESET  = 10'd409;

   // top and bottom floor codes (floor number minus one)
   localparam logic [1:0] FLOOR_BOTTOM = 2'd0;
   localparam logic [1:0] FLOOR_TOP    = 2'd3;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_REQUEST = 3'd1,
      CMD_SENSOR  = 3'd2,
      CMD_ENCODER = 3'd3,
      CMD_REPORT  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MOTION_STOP = 2'd0,
      MOTION_UP   = 2'd1,
      MOTION_DOWN = 2'd2
   } motion_type;

   typedef enum logic [1:0] {
      CSR_DWELL = 2'd0,
      CSR_PAUSE = 2'd1,
      CSR_TOP   = 2'd2,
      CSR_DUTY  = 2'd3
   } csr_type;

endpackage

/* src/four_floor_lift_controller.sv */
// Four-floor lift controller, one event per request beat.
// Request channel (req_*): command plus its operands; a beat is taken when
// req_valid is high and req_stall low. Each beat is handled in the cycle it
// is taken and its answer lands in the result register the next cycle.
// Result channel (rsp_*): one status beat per event, or five telemetry beats
// for a report, the last one flagged by rsp_last_byte. Status fields give the
// state after the event.
// Throughput: one event per cycle for status answers while rsp_stall stays low;
// a report holds the result register until its last telemetry beat has left,
// one telemetry beat at a time, so the next event waits for the last.
// A new event is taken in the same cycle as the final beat of the previous
// answer leaves.
// Stall: while rsp_stall is high a valid result beat holds and req_stall rises.
// Reset (synchronous): the car homes downward until the floor-one sensor
// fires; control registers return to their defaults (dwell 2000, pause 500,
// top count 215, duty 409). csr_* writes land at any edge with csr_we high;
// the user makes them only while no event is in flight, as the block does not enforce it.
module four_floor_lift_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_rx_byte,
   input  logic [1:0]  req_sensor_floor,
   input  logic [9:0]  req_current_raw,
   input  logic [9:0]  req_temp_raw,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_telemetry,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [1:0]  rsp_motion,
   output logic        rsp_dir_up,
   output logic [9:0]  rsp_motor_duty,
   output logic [1:0]  rsp_floor_now,
   output logic [1:0]  rsp_floor_target,
   // control register port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // control registers
   logic [15:0] dwell_ff;
   logic [15:0] pause_ff;
   logic [7:0]  top_ff;
   logic [9:0]  duty_ff;

   // lift state; only the parity of the pulse count is ever reported
   logic                        homing_ff, homing_in;
   fflc_pkg::motion_type        motor_ff, motor_in;
   logic                        dir_ff, dir_in;
   logic [1:0]                  floor_ff, floor_in;
   logic [1:0]                  target_ff, target_in;
   logic [7:0]                  pos_ff, pos_in;
   logic                        speed_ff, speed_in;
   logic [fflc_pkg::TIMER_W-1:0] wait_ff, wait_in;
   logic                        rev_ff, rev_in;

   // result register
   logic                         rsp_valid_ff;
   logic                         tel_ff;
   logic [fflc_pkg::BEAT_W-1:0]  beat_ff;
   logic [7:0]                   bytes_ff [fflc_pkg::N_BEATS];
   logic [7:0]                   bytes_in [fflc_pkg::N_BEATS];
   fflc_pkg::motion_type         st_motion_ff;
   logic                         st_dir_ff;
   logic [9:0]                   st_duty_ff;
   logic [1:0]                   st_floor_ff;
   logic [1:0]                   st_target_ff;

   // scaled telemetry products
   logic [7:0]  pos_pre;
   logic [26:0] pos_prod;
   logic [27:0] cur_prod;

   // handshake
   logic last_beat;
   logic req_take;
   logic fwd_take;

   fflc_pkg::cmd_type cmd;
   assign cmd = fflc_pkg::cmd_type'(req_command);

   assign last_beat = rsp_valid_ff && (!tel_ff || beat_ff == fflc_pkg::LAST_BEAT);
   assign fwd_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && !(last_beat && !rsp_stall);
   assign req_take  = req_valid && !req_stall;

   // telemetry scalings, one constant multiply each
   assign pos_pre  = homing_ff ? 8'd0 : pos_ff;
   assign pos_prod = 27'(pos_pre) * 27'(fflc_pkg::MUL_POS);
   assign cur_prod = 28'(req_current_raw) * 28'(fflc_pkg::MUL_CUR);

   // event handling: next state of the lift
   always_comb begin
      homing_in = homing_ff;
      motor_in  = motor_ff;
      dir_in    = dir_ff;
      floor_in  = floor_ff;
      target_in = target_ff;
      pos_in    = pos_ff;
      speed_in  = speed_ff;
      wait_in   = wait_ff;
      rev_in    = rev_ff;

      // homing: keep driving down with position pinned
      if (homing_in) begin
         motor_in = fflc_pkg::MOTION_DOWN;
         dir_in   = 1'b0;
         pos_in   = 8'd0;
      end

      // telemetry beats see the state before the event proper
      bytes_in[0] = {1'b1, 1'b0, motor_in, 2'b00, floor_in};
      bytes_in[1] = {1'b0, pos_prod[fflc_pkg::DIV_SHIFT + 1 +: 7]};
      bytes_in[2] = {1'b0, speed_in, 6'd0};
      bytes_in[3] = {2'b00, cur_prod[fflc_pkg::DIV_SHIFT + 2 +: 6]};
      bytes_in[4] = {1'b0, req_temp_raw[8:3], 1'b0};

      unique case (cmd)
         fflc_pkg::CMD_TICK: begin
            if (!homing_in && wait_in != '0) begin
               wait_in = wait_in - fflc_pkg::TIMER_W'(1);
               if (wait_in == '0 && rev_in) begin
                  rev_in   = 1'b0;
                  dir_in   = ~dir_in;
                  motor_in = dir_in ? fflc_pkg::MOTION_UP : fflc_pkg::MOTION_DOWN;
               end
            end
         end
         fflc_pkg::CMD_REQUEST: begin
            if (!homing_in && req_rx_byte != 8'd0) begin
               target_in = req_rx_byte[1:0];
            end
         end
         fflc_pkg::CMD_SENSOR: begin
            if (homing_in) begin
               floor_in = req_sensor_floor;
               if (req_sensor_floor == fflc_pkg::FLOOR_BOTTOM) begin
                  // homing done: floor stop
                  homing_in = 1'b0;
                  motor_in  = fflc_pkg::MOTION_STOP;
                  rev_in    = 1'b0;
                  wait_in   = fflc_pkg::TIMER_W'(dwell_ff);
               end else if (req_sensor_floor == fflc_pkg::FLOOR_TOP) begin
                  target_in = fflc_pkg::FLOOR_BOTTOM;
               end
            end else begin
               floor_in = req_sensor_floor;
               if (req_sensor_floor == fflc_pkg::FLOOR_BOTTOM ||
                   req_sensor_floor == fflc_pkg::FLOOR_TOP ||
                   req_sensor_floor == target_in) begin
                  // floor stop; any stop away from the bottom heads back down
                  if (req_sensor_floor != fflc_pkg::FLOOR_BOTTOM) begin
                     target_in = fflc_pkg::FLOOR_BOTTOM;
                  end
                  motor_in = fflc_pkg::MOTION_STOP;
                  rev_in   = 1'b0;
                  wait_in  = fflc_pkg::TIMER_W'(dwell_ff);
               end
            end
         end
         fflc_pkg::CMD_ENCODER: begin
            speed_in = ~speed_in;
            if (homing_in) begin
               pos_in = 8'd0;
            end else if (!dir_in) begin
               if (pos_in != 8'd0) begin
                  pos_in = pos_in - 8'd1;
               end
            end else if (pos_in < top_ff) begin
               pos_in = pos_in + 8'd1;
            end
         end
         fflc_pkg::CMD_REPORT: begin
            speed_in = 1'b0;
         end
         default: begin
         end
      endcase

      // motion decision
      if (!homing_in && wait_in == '0 && target_in != floor_in) begin
         if (floor_in < target_in) begin
            if (motor_in != fflc_pkg::MOTION_STOP && !dir_in) begin
               motor_in = fflc_pkg::MOTION_STOP;
               rev_in   = 1'b1;
               wait_in  = fflc_pkg::TIMER_W'(pause_ff);
            end else begin
               motor_in = fflc_pkg::MOTION_UP;
               dir_in   = 1'b1;
            end
         end else begin
            if (motor_in != fflc_pkg::MOTION_STOP && dir_in) begin
               motor_in = fflc_pkg::MOTION_STOP;
               rev_in   = 1'b1;
               wait_in  = fflc_pkg::TIMER_W'(pause_ff);
            end else begin
               motor_in = fflc_pkg::MOTION_DOWN;
               dir_in   = 1'b0;
            end
         end
      end
   end

   // control registers and lift state
   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff  <= fflc_pkg::DWELL_RESET;
         pause_ff  <= fflc_pkg::PAUSE_RESET;
         top_ff    <= fflc_pkg::TOP_RESET;
         duty_ff   <= fflc_pkg::DUTY_RESET;
         homing_ff <= 1'b1;
         motor_ff  <= fflc_pkg::MOTION_STOP;
         dir_ff    <= 1'b0;
         floor_ff  <= fflc_pkg::FLOOR_BOTTOM;
         target_ff <= fflc_pkg::FLOOR_BOTTOM;
         pos_ff    <= 8'd0;
         speed_ff  <= 1'b0;
         wait_ff   <= '0;
         rev_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (fflc_pkg::csr_type'(csr_index))
               fflc_pkg::CSR_DWELL: dwell_ff <= csr_wdata;
               fflc_pkg::CSR_PAUSE: pause_ff <= csr_wdata;
               fflc_pkg::CSR_TOP:   top_ff   <= csr_wdata[7:0];
               fflc_pkg::CSR_DUTY:  duty_ff  <= csr_wdata[9:0];
               default: begin
               end
            endcase
         end
         if (req_take) begin
            homing_ff <= homing_in;
            motor_ff  <= motor_in;
            dir_ff    <= dir_in;
            floor_ff  <= floor_in;
            target_ff <= target_in;
            pos_ff    <= pos_in;
            speed_ff  <= speed_in;
            wait_ff   <= wait_in;
            rev_ff    <= rev_in;
         end
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tel_ff       <= 1'b0;
         beat_ff      <= '0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
         tel_ff       <= (cmd == fflc_pkg::CMD_REPORT);
         beat_ff      <= '0;
      end else if (fwd_take) begin
         if (last_beat) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + fflc_pkg::BEAT_W'(1);
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         bytes_ff     <= bytes_in;
         st_motion_ff <= motor_in;
         st_dir_ff    <= dir_in;
         st_duty_ff   <= (motor_in != fflc_pkg::MOTION_STOP) ? duty_ff : 10'd0;
         st_floor_ff  <= floor_in;
         st_target_ff <= target_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_telemetry = tel_ff;
   assign rsp_tx_byte      = tel_ff ? bytes_ff[beat_ff] : 8'd0;
   assign rsp_last_byte    = !tel_ff || beat_ff == fflc_pkg::LAST_BEAT;
   assign rsp_motion       = st_motion_ff;
   assign rsp_dir_up       = st_dir_ff;
   assign rsp_motor_duty   = st_duty_ff;
   assign rsp_floor_now    = st_floor_ff;
   assign rsp_floor_target = st_target_ff;

   // position stays pinned at the bottom while homing
   a_home_pos: assert property (@(posedge clock) disable iff (reset)
      homing_ff |-> pos_ff == 8'd0)
      else $error("position moved while homing");

   // homing is never re-entered once left
   a_home_once: assert property (@(posedge clock) disable iff (reset)
      !homing_ff |=> !homing_ff)
      else $error("homing re-entered");

   // a stopped car drives no duty
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && st_motion_ff == fflc_pkg::MOTION_STOP |-> st_duty_ff == 10'd0)
      else $error("duty driven while stopped");

   // telemetry beats advance one at a time with no gap
   a_beat_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tel_ff && !rsp_stall && !last_beat |=>
         rsp_valid_ff && tel_ff && beat_ff == $past(beat_ff) + fflc_pkg::BEAT_W'(1))
      else $error("telemetry beat sequence broken");

endmodule
